// ----- design/cdpp_pkg.sv -----
// ----------------------------------------------------------------------------
// cdpp_pkg
// Shared constants and types of the capsule distance pattern pixel generator.
// ----------------------------------------------------------------------------
package cdpp_pkg;

  // image size
  localparam int unsigned COLS = 512;
  localparam int unsigned ROWS = 512;

  // port widths
  localparam int unsigned COL_W     = 9;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // half-pixel offset from the center, signed
  localparam int unsigned DW     = 14;
  // rotation products and sums
  localparam int unsigned PR_W   = DW + DATA_W;
  localparam int unsigned U_W    = PR_W + 1;
  // magnitudes of rotated coordinates
  localparam int unsigned MAG_W  = PR_W;
  localparam int unsigned LC_W   = MAG_W + 1;
  localparam int unsigned SQP_W  = 2 * MAG_W;
  // square root operand (even width), root and remainder
  localparam int unsigned SQ_W   = SQP_W + 2;
  localparam int unsigned ROOT_W = SQ_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned SQRT_N = ROOT_W;
  // signed distance
  localparam int unsigned D_W    = ROOT_W + 2;
  // falloff band in Q.16
  localparam int unsigned FALL_W = DATA_W + 12;
  // blend numerator and divider
  localparam int unsigned MUL_W  = DATA_W + FALL_W;
  localparam int unsigned NUM_W  = MUL_W + 1;
  localparam int unsigned DIV_N  = DATA_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH  = 3'd0,
    REG_WIDTH   = 3'd1,
    REG_FALLOFF = 3'd2,
    REG_COS     = 3'd3,
    REG_SIN     = 3'd4,
    REG_FG      = 3'd5,
    REG_BG      = 3'd6
  } cfg_idx_e;

  // reset values
  localparam logic [DATA_W-1:0] COS_RESET = 16'h7FFF;
  localparam logic [DATA_W-1:0] FG_RESET  = 16'hFFFF;

  // pixel classification
  typedef enum logic [1:0] {
    CLS_FG,
    CLS_BG,
    CLS_BLEND
  } pix_cls_e;

endpackage

// ----- design/capsule_distance_pattern_pixel_top.sv -----
// ----------------------------------------------------------------------------
// capsule_distance_pattern_pixel_top
// Rotated capsule pattern: rotation, distance with rounded square root,
// linear color blend with rounded division, fully pipelined.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle unless the output stalls; the 31-stage square
//   root and the 16-stage divider set the depth, each stage resolving one result bit
// a stalled output freezes every stage and stalls the input
// reset clears all valid bits and loads the register defaults
module capsule_distance_pattern_pixel_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cdpp_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [cdpp_pkg::DATA_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [cdpp_pkg::COL_W-1:0]      col_i,
  input  logic [cdpp_pkg::COL_W-1:0]      row_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cdpp_pkg::DATA_W-1:0]     pixel_value_o
);

  localparam int unsigned DATA_W = cdpp_pkg::DATA_W;
  localparam int unsigned DW     = cdpp_pkg::DW;
  localparam int unsigned PR_W   = cdpp_pkg::PR_W;
  localparam int unsigned U_W    = cdpp_pkg::U_W;
  localparam int unsigned MAG_W  = cdpp_pkg::MAG_W;
  localparam int unsigned LC_W   = cdpp_pkg::LC_W;
  localparam int unsigned SQP_W  = cdpp_pkg::SQP_W;
  localparam int unsigned SQ_W   = cdpp_pkg::SQ_W;
  localparam int unsigned ROOT_W = cdpp_pkg::ROOT_W;
  localparam int unsigned REM_W  = cdpp_pkg::REM_W;
  localparam int unsigned SQRT_N = cdpp_pkg::SQRT_N;
  localparam int unsigned D_W    = cdpp_pkg::D_W;
  localparam int unsigned FALL_W = cdpp_pkg::FALL_W;
  localparam int unsigned MUL_W  = cdpp_pkg::MUL_W;
  localparam int unsigned NUM_W  = cdpp_pkg::NUM_W;
  localparam int unsigned DIV_N  = cdpp_pkg::DIV_N;
  localparam int unsigned PAD_W  = DW - cdpp_pkg::COL_W - 1;

  // configuration registers
  logic        [DATA_W-1:0] len_q, wid_q, fall_cfg_q, fg_q, bg_q;
  logic signed [DATA_W-1:0] cos_q, sin_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      wid_q      <= '0;
      fall_cfg_q <= '0;
      cos_q      <= cdpp_pkg::COS_RESET;
      sin_q      <= '0;
      fg_q       <= cdpp_pkg::FG_RESET;
      bg_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        cdpp_pkg::REG_LENGTH:  len_q      <= cfg_wdata_i;
        cdpp_pkg::REG_WIDTH:   wid_q      <= cfg_wdata_i;
        cdpp_pkg::REG_FALLOFF: fall_cfg_q <= cfg_wdata_i;
        cdpp_pkg::REG_COS:     cos_q      <= cfg_wdata_i;
        cdpp_pkg::REG_SIN:     sin_q      <= cfg_wdata_i;
        cdpp_pkg::REG_FG:      fg_q       <= cfg_wdata_i;
        cdpp_pkg::REG_BG:      bg_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // derived Q.16 lengths
  logic [FALL_W-1:0] fall_w;
  assign fall_w = {fall_cfg_q, 12'b0};

  // global pipeline advance
  logic en, out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic vr_q, vd_q, vc_q, vm_q, vn_q;

  // stage 1: half-pixel offsets from the center
  logic signed [DW-1:0] dx2_d, dy2_d, dx2_q, dy2_q;
  assign dx2_d = $signed({{PAD_W{1'b0}}, col_i, 1'b0} - DW'(cdpp_pkg::COLS - 1));
  assign dy2_d = $signed(DW'(cdpp_pkg::ROWS - 1) - {{PAD_W{1'b0}}, row_i, 1'b0});

  // stage 2: rotation products
  logic signed [PR_W-1:0] p_xc_q, p_ys_q, p_yc_q, p_xs_q;

  // stage 3: rotated coordinates
  logic signed [U_W-1:0] u_d, v_d, u_q, v_q;
  assign u_d = U_W'(p_xc_q) + U_W'(p_ys_q);
  assign v_d = U_W'(p_yc_q) - U_W'(p_xs_q);

  // stage 4: magnitudes
  logic [MAG_W-1:0] au_d, av_d, au_q, av_q;
  assign au_d = u_q[U_W-1] ? MAG_W'(-u_q) : MAG_W'(u_q);
  assign av_d = v_q[U_W-1] ? MAG_W'(-v_q) : MAG_W'(v_q);

  // stage 5: distance past the half length
  logic signed [LC_W-1:0] lc_d, lc_q;
  logic        [MAG_W-1:0] wc5_q;
  assign lc_d = $signed({1'b0, au_q}) - $signed(LC_W'({len_q, 11'b0}));

  // stage 6: squares
  logic             lcpos_d, lcpos6_q;
  logic [SQP_W-1:0] sql_d, sqw_d, sql_q, sqw_q;
  logic [MAG_W-1:0] wc6_q;
  assign lcpos_d = !lc_q[LC_W-1] && (lc_q != '0);
  assign sql_d   = lc_q[MAG_W-1:0] * lc_q[MAG_W-1:0];
  assign sqw_d   = wc5_q * wc5_q;

  // stage 7: sum of squares
  logic [SQ_W-1:0]  n_d, n_q;
  logic             lcpos7_q;
  logic [MAG_W-1:0] wc7_q;
  assign n_d = SQ_W'(sql_q) + SQ_W'(sqw_q);

  // square root, one root bit per stage
  logic [REM_W-1:0]  sq_rem_in  [SQRT_N];
  logic [ROOT_W-1:0] sq_root_in [SQRT_N];
  logic [SQ_W-1:0]   sq_n_in    [SQRT_N];
  logic              sq_lp_in   [SQRT_N];
  logic [MAG_W-1:0]  sq_wc_in   [SQRT_N];
  logic              sq_v_in    [SQRT_N];
  logic [REM_W-1:0]  sq_rem_q   [SQRT_N];
  logic [ROOT_W-1:0] sq_root_q  [SQRT_N];
  logic [SQ_W-1:0]   sq_n_q     [SQRT_N];
  logic              sq_lp_q    [SQRT_N];
  logic [MAG_W-1:0]  sq_wc_q    [SQRT_N];
  logic              sq_v_q     [SQRT_N];

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    logic [REM_W+1:0] rem_t;
    logic [REM_W+1:0] trial;
    logic             take;

    // stage input
    if (k == 0) begin : g_first
      assign sq_rem_in[k]  = '0;
      assign sq_root_in[k] = '0;
      assign sq_n_in[k]    = n_q;
      assign sq_lp_in[k]   = lcpos7_q;
      assign sq_wc_in[k]   = wc7_q;
      assign sq_v_in[k]    = v7_q;
    end else begin : g_next
      assign sq_rem_in[k]  = sq_rem_q[k-1];
      assign sq_root_in[k] = sq_root_q[k-1];
      assign sq_n_in[k]    = sq_n_q[k-1];
      assign sq_lp_in[k]   = sq_lp_q[k-1];
      assign sq_wc_in[k]   = sq_wc_q[k-1];
      assign sq_v_in[k]    = sq_v_q[k-1];
    end

    // trial subtract of 4*root+1
    assign rem_t = {sq_rem_in[k], sq_n_in[k][SQ_W-1 -: 2]};
    assign trial = (REM_W+2)'({sq_root_in[k], 2'b01});
    assign take  = (rem_t >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k]  <= take ? REM_W'(rem_t - trial) : REM_W'(rem_t);
        sq_root_q[k] <= {sq_root_in[k][ROOT_W-2:0], take};
        sq_n_q[k]    <= {sq_n_in[k][SQ_W-3:0], 2'b00};
        sq_lp_q[k]   <= sq_lp_in[k];
        sq_wc_q[k]   <= sq_wc_in[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= sq_v_in[k];
      end
    end
  end

  // round to nearest
  logic [ROOT_W-1:0] root_f;
  logic [REM_W-1:0]  rem_f;
  logic [ROOT_W:0]   rnd_d, rnd_q;
  logic              lpr_q;
  logic [MAG_W-1:0]  wcr_q;
  assign root_f = sq_root_q[SQRT_N-1];
  assign rem_f  = sq_rem_q[SQRT_N-1];
  assign rnd_d  = (rem_f > REM_W'(root_f)) ? (ROOT_W+1)'(root_f) + 1'b1
                                           : (ROOT_W+1)'(root_f);

  // signed distance outside the capsule
  logic [ROOT_W:0]       base_d;
  logic signed [D_W-1:0] dist_d, dist_q;
  assign base_d = lpr_q ? rnd_q : (ROOT_W+1)'(wcr_q);
  assign dist_d = $signed({1'b0, base_d}) - $signed(D_W'({wid_q, 11'b0}));

  // classify and form blend weights
  cdpp_pkg::pix_cls_e cls_d, cls_q, clsm_q, clsn_q;
  logic [FALL_W-1:0]  dd_d, fd_d, dd_q, fd_q;
  always_comb begin
    if (dist_q[D_W-1] || (dist_q == '0)) begin
      cls_d = cdpp_pkg::CLS_FG;
    end else if (dist_q[D_W-2:0] > (D_W-1)'(fall_w)) begin
      cls_d = cdpp_pkg::CLS_BG;
    end else begin
      cls_d = cdpp_pkg::CLS_BLEND;
    end
  end
  assign dd_d = dist_q[FALL_W-1:0];
  assign fd_d = fall_w - dist_q[FALL_W-1:0];

  // blend products
  logic [MUL_W-1:0] pf_d, pb_d, pf_q, pb_q;
  assign pf_d = fg_q * fd_q;
  assign pb_d = bg_q * dd_q;

  // numerator with half-divisor rounding
  logic [NUM_W-1:0] num_d, num_q;
  assign num_d = NUM_W'(pf_q) + NUM_W'(pb_q) + NUM_W'(fall_w >> 1);

  // divider, one quotient bit per stage
  logic [FALL_W-1:0]          dv_rem_in [DIV_N];
  logic [DATA_W-1:0]          dv_lo_in  [DIV_N];
  logic [DATA_W-1:0]          dv_quo_in [DIV_N];
  cdpp_pkg::pix_cls_e         dv_cls_in [DIV_N];
  logic                       dv_v_in   [DIV_N];
  logic [FALL_W-1:0]          dv_rem_q  [DIV_N];
  logic [DATA_W-1:0]          dv_lo_q   [DIV_N];
  logic [DATA_W-1:0]          dv_quo_q  [DIV_N];
  cdpp_pkg::pix_cls_e         dv_cls_q  [DIV_N];
  logic                       dv_v_q    [DIV_N];

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    logic [FALL_W:0] rem_t;
    logic            take;

    // stage input
    if (i == 0) begin : g_first
      assign dv_rem_in[i] = num_q[DATA_W+FALL_W-1:DATA_W];
      assign dv_lo_in[i]  = num_q[DATA_W-1:0];
      assign dv_quo_in[i] = '0;
      assign dv_cls_in[i] = clsn_q;
      assign dv_v_in[i]   = vn_q;
    end else begin : g_next
      assign dv_rem_in[i] = dv_rem_q[i-1];
      assign dv_lo_in[i]  = dv_lo_q[i-1];
      assign dv_quo_in[i] = dv_quo_q[i-1];
      assign dv_cls_in[i] = dv_cls_q[i-1];
      assign dv_v_in[i]   = dv_v_q[i-1];
    end

    // shift in next numerator bit, trial subtract
    assign rem_t = {dv_rem_in[i], dv_lo_in[i][DATA_W-1]};
    assign take  = (rem_t >= {1'b0, fall_w});

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[i] <= take ? FALL_W'(rem_t - {1'b0, fall_w}) : FALL_W'(rem_t);
        dv_lo_q[i]  <= {dv_lo_in[i][DATA_W-2:0], 1'b0};
        dv_quo_q[i] <= {dv_quo_in[i][DATA_W-2:0], take};
        dv_cls_q[i] <= dv_cls_in[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[i] <= 1'b0;
      end else if (en) begin
        dv_v_q[i] <= dv_v_in[i];
      end
    end
  end

  // output color select
  logic [DATA_W-1:0] pix_d, pix_q;
  always_comb begin
    case (dv_cls_q[DIV_N-1])
      cdpp_pkg::CLS_FG:    pix_d = fg_q;
      cdpp_pkg::CLS_BG:    pix_d = bg_q;
      cdpp_pkg::CLS_BLEND: pix_d = dv_quo_q[DIV_N-1];
      default:             pix_d = bg_q;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx2_q    <= dx2_d;
      dy2_q    <= dy2_d;
      p_xc_q   <= PR_W'(dx2_q) * PR_W'(cos_q);
      p_ys_q   <= PR_W'(dy2_q) * PR_W'(sin_q);
      p_yc_q   <= PR_W'(dy2_q) * PR_W'(cos_q);
      p_xs_q   <= PR_W'(dx2_q) * PR_W'(sin_q);
      u_q      <= u_d;
      v_q      <= v_d;
      au_q     <= au_d;
      av_q     <= av_d;
      lc_q     <= lc_d;
      wc5_q    <= av_q;
      lcpos6_q <= lcpos_d;
      sql_q    <= sql_d;
      sqw_q    <= sqw_d;
      wc6_q    <= wc5_q;
      n_q      <= n_d;
      lcpos7_q <= lcpos6_q;
      wc7_q    <= wc6_q;
      rnd_q    <= rnd_d;
      lpr_q    <= sq_lp_q[SQRT_N-1];
      wcr_q    <= sq_wc_q[SQRT_N-1];
      dist_q   <= dist_d;
      cls_q    <= cls_d;
      dd_q     <= dd_d;
      fd_q     <= fd_d;
      clsm_q   <= cls_q;
      pf_q     <= pf_d;
      pb_q     <= pb_d;
      clsn_q   <= clsm_q;
      num_q    <= num_d;
      pix_q    <= pix_d;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      vr_q        <= 1'b0;
      vd_q        <= 1'b0;
      vc_q        <= 1'b0;
      vm_q        <= 1'b0;
      vn_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      vr_q        <= sq_v_q[SQRT_N-1];
      vd_q        <= vr_q;
      vc_q        <= vd_q;
      vm_q        <= vc_q;
      vn_q        <= vm_q;
      out_valid_q <= dv_v_q[DIV_N-1];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pix_q;

endmodule

// ----- test/capsule_distance_pattern_pixel_top_test.sv -----
// ----------------------------------------------------------------------------
// capsule_distance_pattern_pixel_top_test
// Self-checking bench for the rotated capsule pattern generator. A driver
// offers pixel coordinates from a job queue, with register writes between
// phases while the pipeline is empty. A monitor compares every output
// transfer with a bit-exact prediction of the pattern value, under random
// gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module capsule_distance_pattern_pixel_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLS      = cdpp_pkg::COLS;
  localparam int unsigned ROWS      = cdpp_pkg::ROWS;
  localparam int unsigned COL_W     = cdpp_pkg::COL_W;
  localparam int unsigned DATA_W    = cdpp_pkg::DATA_W;
  localparam int unsigned CFG_IDX_W = cdpp_pkg::CFG_IDX_W;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int SETTLE_EDGES = 4;
  localparam int HOLD_EDGES   = 300;
  localparam int TAIL_EDGES   = 100;

  typedef enum int {JOB_PIXEL, JOB_CFG, JOB_DRAIN, JOB_HOLD} job_kind_e;

  typedef struct {
    job_kind_e            kind;
    logic [COL_W-1:0]     col;
    logic [COL_W-1:0]     row;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
    int                   gap;
  } raster_job_t;

  typedef struct {
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  row;
    logic [DATA_W-1:0] value;
  } owed_pixel_t;

  // dut ports
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i  = '0;
  logic [DATA_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [COL_W-1:0]     col_i       = '0;
  logic [COL_W-1:0]     row_i       = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DATA_W-1:0]    pixel_value_o;

  // shadow copy of the configuration registers
  logic [DATA_W-1:0] r_len  = '0;
  logic [DATA_W-1:0] r_wid  = '0;
  logic [DATA_W-1:0] r_fall = '0;
  logic [DATA_W-1:0] r_cos  = cdpp_pkg::COS_RESET;
  logic [DATA_W-1:0] r_sin  = '0;
  logic [DATA_W-1:0] r_fg   = cdpp_pkg::FG_RESET;
  logic [DATA_W-1:0] r_bg   = '0;

  raster_job_t raster_jobs[$];
  owed_pixel_t owed_pixels[$];

  int  n_errors   = 0;
  int  n_pixels   = 0;
  int  n_results  = 0;
  int  n_writes   = 0;
  int  n_settings = 0;
  int  n_held     = 0;
  bit  hold_req   = 1'b0;

  capsule_distance_pattern_pixel_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .col_i         (col_i),
    .row_i         (row_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // integer square root, rounded to nearest
  function automatic longint unsigned isqrt_round(input longint unsigned n);
    longint unsigned res;
    longint unsigned bit_v;
    res   = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n   -= res + bit_v;
        res  = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    if (n > res) res++;
    return res;
  endfunction

  // pattern value of one pixel under the shadow registers
  function automatic logic [DATA_W-1:0] capsule_pixel(input logic [COL_W-1:0] col,
                                                      input logic [COL_W-1:0] row);
    longint dx2, dy2, c, s, half_len, half_wid, band, u, v, lc, wc, d, num;
    dx2      = 2 * longint'(col) - (longint'(COLS) - 1);
    dy2      = (longint'(ROWS) - 1) - 2 * longint'(row);
    c        = longint'(signed'(r_cos));
    s        = longint'(signed'(r_sin));
    half_len = longint'(r_len) << 11;
    half_wid = longint'(r_wid) << 11;
    band     = longint'(r_fall) << 12;
    u        = dx2 * c + dy2 * s;
    v        = dy2 * c - dx2 * s;
    lc       = ((u < 0) ? -u : u) - half_len;
    wc       = (v < 0) ? -v : v;
    // straight side, or distance to the nearer end cap
    if (lc <= 0) d = wc - half_wid;
    else d = longint'(isqrt_round(longint'(lc * lc + wc * wc))) - half_wid;
    if (d <= 0) return r_fg;
    if (d > band) return r_bg;
    num = longint'(r_fg) * (band - d) + longint'(r_bg) * d;
    return DATA_W'((num + band / 2) / band);
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic push_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                            input int gap);
    raster_job_t j;
    j      = '{kind: JOB_PIXEL, col: col, row: row, idx: '0, data: '0, gap: gap};
    raster_jobs.push_back(j);
  endtask

  task automatic push_job(input job_kind_e kind, input logic [CFG_IDX_W-1:0] idx,
                          input logic [DATA_W-1:0] data);
    raster_job_t j;
    j = '{kind: kind, col: '0, row: '0, idx: idx, data: data, gap: 0};
    raster_jobs.push_back(j);
  endtask

  task automatic write_regs(input logic [DATA_W-1:0] len, input logic [DATA_W-1:0] wid,
                            input logic [DATA_W-1:0] fall, input logic [DATA_W-1:0] cs,
                            input logic [DATA_W-1:0] sn, input logic [DATA_W-1:0] fg,
                            input logic [DATA_W-1:0] bg);
    push_job(JOB_CFG, cdpp_pkg::REG_LENGTH, len);
    push_job(JOB_CFG, cdpp_pkg::REG_WIDTH, wid);
    push_job(JOB_CFG, cdpp_pkg::REG_FALLOFF, fall);
    push_job(JOB_CFG, cdpp_pkg::REG_COS, cs);
    push_job(JOB_CFG, cdpp_pkg::REG_SIN, sn);
    push_job(JOB_CFG, cdpp_pkg::REG_FG, fg);
    push_job(JOB_CFG, cdpp_pkg::REG_BG, bg);
    n_settings++;
  endtask

  // one random setting followed by raster runs and scattered pixels
  task automatic random_phase(input int n, input bit pressure);
    int left, k, j, gap;
    logic [COL_W-1:0] c, r;
    real a;
    bit burst, paused;
    a      = $urandom_range(0, 62831) / 10000.0;
    paused = 1'b0;
    if ($urandom_range(0, 4) == 0)
      write_regs(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                 DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                 DATA_W'($urandom));
    else
      write_regs(DATA_W'($urandom_range(0, 9600)), DATA_W'($urandom_range(0, 4800)),
                 ($urandom_range(0, 5) == 0) ? '0 : DATA_W'($urandom_range(1, 3200)),
                 DATA_W'(int'(32767.0 * $cos(a))), DATA_W'(int'(32767.0 * $sin(a))),
                 DATA_W'($urandom), DATA_W'($urandom));
    if (pressure) push_job(JOB_HOLD, '0, '0);
    left = n;
    while (left > 0) begin
      // sender waits once for the pipeline to empty
      if (!pressure && !paused && left <= n / 2) begin
        push_job(JOB_DRAIN, '0, '0);
        paused = 1'b1;
      end
      burst = (pressure && (n - left) < 150) || ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) begin
        r = COL_W'($urandom);
        c = COL_W'($urandom);
        k = $urandom_range(1, 24);
        for (j = 0; j < k && left > 0; j++) begin
          gap = burst ? 0 : pick_gap();
          push_pixel(c, r, gap);
          c = c + 1'b1;
          left--;
        end
      end else begin
        gap = burst ? 0 : pick_gap();
        push_pixel(COL_W'($urandom), COL_W'($urandom), gap);
        left--;
      end
    end
  endtask

  // driver
  bit          drv_fire, drv_valid, drv_we;
  int          gap_left   = 0;
  int          idle_edges = 0;
  raster_job_t drv_job;
  owed_pixel_t drv_owed;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      drv_fire = in_valid_i && !in_stall_o;
      if (drv_fire) begin
        drv_owed.col   = col_i;
        drv_owed.row   = row_i;
        drv_owed.value = capsule_pixel(col_i, row_i);
        owed_pixels.push_back(drv_owed);
        n_pixels++;
      end
      if (in_valid_i && in_stall_o) n_held++;
      if (owed_pixels.size() == 0 && !in_valid_i) idle_edges++;
      else idle_edges = 0;

      drv_valid = in_valid_i && !drv_fire;
      drv_we    = 1'b0;
      if (!drv_valid && gap_left > 0) begin
        gap_left--;
      end else if (!drv_valid && raster_jobs.size() > 0) begin
        drv_job = raster_jobs[0];
        case (drv_job.kind)
          JOB_PIXEL: begin
            col_i     <= drv_job.col;
            row_i     <= drv_job.row;
            drv_valid  = 1'b1;
            gap_left   = drv_job.gap;
            raster_jobs.delete(0);
          end
          JOB_CFG: begin
            // registers change only with the pipeline empty
            if (idle_edges >= SETTLE_EDGES) begin
              drv_we       = 1'b1;
              cfg_addr_i  <= drv_job.idx;
              cfg_wdata_i <= drv_job.data;
              case (drv_job.idx)
                cdpp_pkg::REG_LENGTH:  r_len  = drv_job.data;
                cdpp_pkg::REG_WIDTH:   r_wid  = drv_job.data;
                cdpp_pkg::REG_FALLOFF: r_fall = drv_job.data;
                cdpp_pkg::REG_COS:     r_cos  = drv_job.data;
                cdpp_pkg::REG_SIN:     r_sin  = drv_job.data;
                cdpp_pkg::REG_FG:      r_fg   = drv_job.data;
                cdpp_pkg::REG_BG:      r_bg   = drv_job.data;
                default: ;
              endcase
              n_writes++;
              raster_jobs.delete(0);
            end
          end
          JOB_DRAIN: begin
            if (idle_edges >= SETTLE_EDGES) raster_jobs.delete(0);
          end
          default: begin
            hold_req = 1'b1;
            raster_jobs.delete(0);
          end
        endcase
      end
      in_valid_i <= drv_valid;
      cfg_we_i   <= drv_we;
    end
  end

  // monitor and output back-pressure
  bit          mon_stall;
  int          hold_left  = 0;
  int          stall_left = 0;
  int          run_left   = 0;
  owed_pixel_t mon_owed;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel_value %h with no pixel outstanding",
                                    pixel_value_o));
        end else begin
          mon_owed = owed_pixels.pop_front();
          n_results++;
          if (pixel_value_o !== mon_owed.value)
            report_mismatch($sformatf("col %0d row %0d: pixel_value %h, predicted %h",
                                      mon_owed.col, mon_owed.row, pixel_value_o,
                                      mon_owed.value));
        end
      end
      // long hold-off on request, else random runs and stalls
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_EDGES;
      end
      if (hold_left > 0) begin
        hold_left--;
        mon_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        mon_stall = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        mon_stall = 1'b0;
      end else begin
        run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 12);
        stall_left = pick_gap();
        mon_stall  = 1'b0;
      end
      out_stall_i <= mon_stall;
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int p;
    // reset defaults: no band, tiny capsule
    push_pixel(9'd0, 9'd0, 0);
    push_pixel(9'd511, 9'd511, 0);
    push_pixel(9'd255, 9'd255, 0);
    push_pixel(9'd256, 9'd0, 0);
    // upright capsule: inside, edge, band and outside
    write_regs(16'd3200, 16'd1280, 16'd480, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000);
    push_pixel(9'd256, 9'd256, 0);
    push_pixel(9'd380, 9'd256, 0);
    push_pixel(9'd395, 9'd256, 0);
    push_pixel(9'd400, 9'd256, 0);
    push_pixel(9'd410, 9'd256, 0);
    push_pixel(9'd420, 9'd256, 0);
    push_pixel(9'd511, 9'd256, 0);
    push_pixel(9'd0, 9'd256, 0);
    push_pixel(9'd256, 9'd200, 0);
    push_pixel(9'd256, 9'd215, 0);
    push_pixel(9'd256, 9'd220, 0);
    // zero falloff, most negative cosine and sine, colors swapped
    write_regs(16'd0, 16'd1600, 16'd0, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF);
    push_pixel(9'd0, 9'd0, 0);
    push_pixel(9'd511, 9'd511, 0);
    push_pixel(9'd256, 9'd256, 0);
    push_pixel(9'd511, 9'd0, 0);
    push_pixel(9'd0, 9'd511, 0);
    // largest lengths cover the whole image
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd23170, 16'd23170, 16'h5A5A, 16'hA5A5);
    push_pixel(9'd0, 9'd511, 0);
    // unmapped register index leaves the registers alone
    push_job(JOB_CFG, REG_UNMAPPED, 16'h0000);
    push_pixel(9'd511, 9'd0, 0);
    // point capsule with a wide band, rotation off the unit circle
    write_regs(16'd0, 16'd0, 16'hFFFF, 16'd12345, 16'hADB0, 16'd1234, 16'hFFFF);
    push_pixel(9'd0, 9'd0, 0);
    push_pixel(9'd300, 9'd100, 0);
    push_pixel(9'd511, 9'd511, 0);
    // random settings, one phase under a long output hold-off
    for (p = 0; p < 8; p++) random_phase((p == 1) ? 160 : $urandom_range(65, 90), p == 1);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (raster_jobs.size() != 0 || in_valid_i || owed_pixels.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_EDGES) @(posedge clk_i);

    $display("ran %0d pixel transfers under %0d register settings, %0d register writes",
             n_pixels, n_settings, n_writes);
    $display("checked %0d results; input stalled %0d cycles by back-pressure",
             n_results, n_held);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
